/* design/euclidean_distance_pythagorean_sum_macros.svh */
// Assertion macros used by the controller design file (edps_ctrl).
`ifndef EUCLIDEAN_DISTANCE_PYTHAGOREAN_SUM_MACROS_SVH
`define EUCLIDEAN_DISTANCE_PYTHAGOREAN_SUM_MACROS_SVH

`ifndef ASSERT_OFF
// Clocked check, held off while reset is asserted.
`define EDPS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also holds during reset.
`define EDPS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define EDPS_ASSERT(lbl, prop, msg)
`define EDPS_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* design/edps_pkg.sv */
package edps_pkg;

    localparam int COORD_W    = 24;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int ITERATIONS = 4;
    localparam int PASS_W     = $clog2(ITERATIONS + 1);
    localparam int EXTRA_FRAC = 16;
    localparam int PQ_W       = 48;
    localparam int FRAC_W     = 32;
    localparam int PROD_W     = 2 * FRAC_W;
    localparam int HI_W       = PQ_W - FRAC_W;
    localparam int DIV_CNT_W  = $clog2(FRAC_W);
    localparam int DIST_W     = 25;
    localparam int SQ_W       = 49;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL_DX,
        OP_MUL_DY,
        OP_SQ_ADD,
        OP_DIVQ_INIT,
        OP_DIV_STEP,
        OP_MUL_T,
        OP_DIVS_INIT,
        OP_MUL_PLO,
        OP_MUL_PHI,
        OP_P_UPD,
        OP_MUL_QLO,
        OP_MUL_QHI,
        OP_Q_UPD,
        OP_EMIT
    } dp_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQX,
        ST_SQY,
        ST_SQSUM,
        ST_QINIT,
        ST_QDIV,
        ST_TSQ,
        ST_RCHK,
        ST_SDIV,
        ST_PLO,
        ST_PHI,
        ST_PUPD,
        ST_QLO,
        ST_QHI,
        ST_QUPD,
        ST_DONE
    } state_t;

    typedef struct packed {
        dp_op_t op;
    } cmd_t;

    typedef struct packed {
        logic p_zero;
        logic r_zero;
        logic div_last;
        logic out_free;
    } status_t;

endpackage

/* design/edps_in_if.sv */
interface edps_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [edps_pkg::COORD_W-1:0]  from_x;
    logic signed [edps_pkg::COORD_W-1:0]  from_y;
    logic signed [edps_pkg::COORD_W-1:0]  to_x;
    logic signed [edps_pkg::COORD_W-1:0]  to_y;

    modport source (output valid, from_x, from_y, to_x, to_y, input ready);
    modport sink (input valid, from_x, from_y, to_x, to_y, output ready);
endinterface

/* design/edps_out_if.sv */
interface edps_out_if;
    logic                          valid;
    logic                          ready;
    logic [edps_pkg::DIST_W-1:0]   distance;
    logic [edps_pkg::SQ_W-1:0]     squared_distance;

    modport source (output valid, distance, squared_distance, input ready);
    modport sink (input valid, distance, squared_distance, output ready);
endinterface

/* design/edps_ctrl.sv */
`include "euclidean_distance_pythagorean_sum_macros.svh"

module edps_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  edps_pkg::status_t  status,
    output edps_pkg::cmd_t     cmd
);

    edps_pkg::state_t            state_reg, state_next;
    logic [edps_pkg::PASS_W-1:0] pass_reg, pass_next;
    logic                        last_pass;

    assign last_pass = (pass_reg == edps_pkg::PASS_W'(edps_pkg::ITERATIONS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= edps_pkg::ST_IDLE;
            pass_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pass_reg  <= pass_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        pass_next  = pass_reg;
        unique case (state_reg)
            edps_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = edps_pkg::ST_SQX;
                    pass_next  = '0;
                end
            end
            edps_pkg::ST_SQX:   state_next = edps_pkg::ST_SQY;
            edps_pkg::ST_SQY:   state_next = edps_pkg::ST_SQSUM;
            edps_pkg::ST_SQSUM:
                state_next = status.p_zero ? edps_pkg::ST_DONE : edps_pkg::ST_QINIT;
            edps_pkg::ST_QINIT: state_next = edps_pkg::ST_QDIV;
            edps_pkg::ST_QDIV:
            begin
                if (status.div_last)
                    state_next = edps_pkg::ST_TSQ;
            end
            edps_pkg::ST_TSQ:   state_next = edps_pkg::ST_RCHK;
            edps_pkg::ST_RCHK:
                state_next = status.r_zero ? edps_pkg::ST_DONE : edps_pkg::ST_SDIV;
            edps_pkg::ST_SDIV:
            begin
                if (status.div_last)
                    state_next = edps_pkg::ST_PLO;
            end
            edps_pkg::ST_PLO:   state_next = edps_pkg::ST_PHI;
            edps_pkg::ST_PHI:   state_next = edps_pkg::ST_PUPD;
            edps_pkg::ST_PUPD:  state_next = edps_pkg::ST_QLO;
            edps_pkg::ST_QLO:   state_next = edps_pkg::ST_QHI;
            edps_pkg::ST_QHI:   state_next = edps_pkg::ST_QUPD;
            edps_pkg::ST_QUPD:
            begin
                if (last_pass)
                    state_next = edps_pkg::ST_DONE;
                else
                begin
                    state_next = edps_pkg::ST_QINIT;
                    pass_next  = pass_reg + 1'b1;
                end
            end
            edps_pkg::ST_DONE:
            begin
                if (status.out_free)
                    state_next = edps_pkg::ST_IDLE;
            end
            default: state_next = edps_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready = 1'b0;
        cmd.op   = edps_pkg::OP_NONE;
        unique case (state_reg)
            edps_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                    cmd.op = edps_pkg::OP_LOAD;
            end
            edps_pkg::ST_SQX:   cmd.op = edps_pkg::OP_MUL_DX;
            edps_pkg::ST_SQY:   cmd.op = edps_pkg::OP_MUL_DY;
            edps_pkg::ST_SQSUM: cmd.op = edps_pkg::OP_SQ_ADD;
            edps_pkg::ST_QINIT: cmd.op = edps_pkg::OP_DIVQ_INIT;
            edps_pkg::ST_QDIV, edps_pkg::ST_SDIV:
                cmd.op = edps_pkg::OP_DIV_STEP;
            edps_pkg::ST_TSQ:   cmd.op = edps_pkg::OP_MUL_T;
            edps_pkg::ST_RCHK:
            begin
                if (!status.r_zero)
                    cmd.op = edps_pkg::OP_DIVS_INIT;
            end
            edps_pkg::ST_PLO:   cmd.op = edps_pkg::OP_MUL_PLO;
            edps_pkg::ST_PHI:   cmd.op = edps_pkg::OP_MUL_PHI;
            edps_pkg::ST_PUPD:  cmd.op = edps_pkg::OP_P_UPD;
            edps_pkg::ST_QLO:   cmd.op = edps_pkg::OP_MUL_QLO;
            edps_pkg::ST_QHI:   cmd.op = edps_pkg::OP_MUL_QHI;
            edps_pkg::ST_QUPD:  cmd.op = edps_pkg::OP_Q_UPD;
            edps_pkg::ST_DONE:
            begin
                if (status.out_free)
                    cmd.op = edps_pkg::OP_EMIT;
            end
            default: cmd.op = edps_pkg::OP_NONE;
        endcase
    end

    `EDPS_ASSERT(a_accept_starts, (in_valid && in_ready) |=> (state_reg == edps_pkg::ST_SQX), "accepted transaction did not start the sequence")
    `EDPS_ASSERT(a_div_holds, (state_reg == edps_pkg::ST_QDIV && !status.div_last) |=> (state_reg == edps_pkg::ST_QDIV), "ratio division left early")
    `EDPS_ASSERT_ALWAYS(a_pass_range, pass_reg <= edps_pkg::PASS_W'(edps_pkg::ITERATIONS - 1), "pass count out of range")

endmodule

/* design/edps_datapath.sv */
module edps_datapath (
    input  logic               clk,
    input  logic               rst_n,
    edps_in_if.sink            pts,
    edps_out_if.source         res,
    input  edps_pkg::cmd_t     cmd,
    output edps_pkg::status_t  status
);

    logic [edps_pkg::DIFF_W-1:0]    dx_reg, dy_reg;
    logic [edps_pkg::PQ_W-1:0]      p_reg, q_reg, rem_reg, dvs_reg;
    logic [edps_pkg::FRAC_W-1:0]    quo_reg, acc_reg;
    logic [edps_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic [edps_pkg::PROD_W-1:0]    prod_reg;
    logic [edps_pkg::SQ_W-1:0]      sq_reg, sqo_reg;
    logic [edps_pkg::DIST_W-1:0]    dist_reg;
    logic                           out_valid_reg;

    logic signed [edps_pkg::DIFF_W-1:0] ddx, ddy;
    logic [edps_pkg::DIFF_W-1:0]        adx, ady, dmax, dmin;
    logic [edps_pkg::FRAC_W-1:0]        mul_a, mul_b;
    logic [edps_pkg::PQ_W:0]            sh;
    logic                               ge;
    logic [edps_pkg::FRAC_W-1:0]        prod_hi;

    assign ddx  = edps_pkg::DIFF_W'(pts.to_x) - edps_pkg::DIFF_W'(pts.from_x);
    assign ddy  = edps_pkg::DIFF_W'(pts.to_y) - edps_pkg::DIFF_W'(pts.from_y);
    assign adx  = ddx[edps_pkg::DIFF_W-1] ? edps_pkg::DIFF_W'(-ddx) : edps_pkg::DIFF_W'(ddx);
    assign ady  = ddy[edps_pkg::DIFF_W-1] ? edps_pkg::DIFF_W'(-ddy) : edps_pkg::DIFF_W'(ddy);
    assign dmax = (adx > ady) ? adx : ady;
    assign dmin = (adx > ady) ? ady : adx;

    assign prod_hi = prod_reg[edps_pkg::PROD_W-1:edps_pkg::FRAC_W];

    // one restoring division step
    assign sh = {rem_reg, 1'b0};
    assign ge = (sh >= {1'b0, dvs_reg});

    // shared multiplier operand selection
    always_comb
    begin
        mul_a = '0;
        mul_b = quo_reg;
        case (cmd.op)
            edps_pkg::OP_MUL_DX:
            begin
                mul_a = edps_pkg::FRAC_W'(dx_reg);
                mul_b = edps_pkg::FRAC_W'(dx_reg);
            end
            edps_pkg::OP_MUL_DY:
            begin
                mul_a = edps_pkg::FRAC_W'(dy_reg);
                mul_b = edps_pkg::FRAC_W'(dy_reg);
            end
            edps_pkg::OP_MUL_T:   mul_a = quo_reg;
            edps_pkg::OP_MUL_PLO: mul_a = p_reg[edps_pkg::FRAC_W-1:0];
            edps_pkg::OP_MUL_PHI:
                mul_a = edps_pkg::FRAC_W'(p_reg[edps_pkg::PQ_W-1:edps_pkg::FRAC_W]);
            edps_pkg::OP_MUL_QLO: mul_a = q_reg[edps_pkg::FRAC_W-1:0];
            edps_pkg::OP_MUL_QHI:
                mul_a = edps_pkg::FRAC_W'(q_reg[edps_pkg::PQ_W-1:edps_pkg::FRAC_W]);
            default: mul_a = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            edps_pkg::OP_LOAD:
            begin
                dx_reg <= adx;
                dy_reg <= ady;
                p_reg  <= edps_pkg::PQ_W'({dmax, edps_pkg::EXTRA_FRAC'(0)});
                q_reg  <= edps_pkg::PQ_W'({dmin, edps_pkg::EXTRA_FRAC'(0)});
            end
            edps_pkg::OP_MUL_DX, edps_pkg::OP_MUL_T, edps_pkg::OP_MUL_PLO,
            edps_pkg::OP_MUL_QLO:
                prod_reg <= mul_a * mul_b;
            edps_pkg::OP_MUL_DY:
            begin
                sq_reg   <= prod_reg[edps_pkg::SQ_W-1:0];
                prod_reg <= mul_a * mul_b;
            end
            edps_pkg::OP_SQ_ADD:
                sq_reg <= sq_reg + prod_reg[edps_pkg::SQ_W-1:0];
            edps_pkg::OP_DIVQ_INIT:
            begin
                rem_reg <= q_reg;
                dvs_reg <= p_reg;
                quo_reg <= '0;
                cnt_reg <= '0;
            end
            edps_pkg::OP_DIVS_INIT:
            begin
                rem_reg <= edps_pkg::PQ_W'(prod_hi);
                dvs_reg <= (edps_pkg::PQ_W'(4) << edps_pkg::FRAC_W)
                           + edps_pkg::PQ_W'(prod_hi);
                quo_reg <= '0;
                cnt_reg <= '0;
            end
            edps_pkg::OP_DIV_STEP:
            begin
                rem_reg <= ge ? edps_pkg::PQ_W'(sh - {1'b0, dvs_reg})
                              : edps_pkg::PQ_W'(sh);
                quo_reg <= {quo_reg[edps_pkg::FRAC_W-2:0], ge};
                cnt_reg <= cnt_reg + 1'b1;
            end
            edps_pkg::OP_MUL_PHI, edps_pkg::OP_MUL_QHI:
            begin
                acc_reg  <= prod_hi;
                prod_reg <= mul_a * mul_b;
            end
            edps_pkg::OP_P_UPD:
                p_reg <= p_reg + edps_pkg::PQ_W'((edps_pkg::PQ_W'(prod_reg)
                                                  + edps_pkg::PQ_W'(acc_reg)) << 1);
            edps_pkg::OP_Q_UPD:
                q_reg <= edps_pkg::PQ_W'(prod_reg) + edps_pkg::PQ_W'(acc_reg);
            edps_pkg::OP_EMIT:
            begin
                dist_reg <= p_reg[edps_pkg::EXTRA_FRAC +: edps_pkg::DIST_W];
                sqo_reg  <= sq_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.op == edps_pkg::OP_EMIT)
            out_valid_reg <= 1'b1;
        else if (res.ready)
            out_valid_reg <= 1'b0;
    end

    assign res.valid            = out_valid_reg;
    assign res.distance         = dist_reg;
    assign res.squared_distance = sqo_reg;

    assign status.p_zero   = (p_reg == '0);
    assign status.r_zero   = (prod_hi == '0);
    assign status.div_last = (cnt_reg == '1);
    assign status.out_free = !out_valid_reg || res.ready;

endmodule

/* design/euclidean_distance_pythagorean_sum.sv */
// Euclidean distance between two points given in signed Q15.8, computed with
// the Pythagorean-sum iteration instead of a square root, plus the exact
// squared distance in Q33.16. One transaction in gives one transaction out.
// The block works on one transaction at a time. It runs up to 4 passes of the
// iteration; it stops at once when the points coincide, and it stops early
// when the ratio term reaches zero within a pass. The time is set by the
// shared one-bit-per-cycle restoring divider (up to two 32-step divisions
// per pass) and the single 32x32 multiplier that all products go through. A
// finished result sits in an output register, so the next transaction is
// taken while it waits; a further result is held back until that register
// is free.
module euclidean_distance_pythagorean_sum (
    input  logic        clk,
    input  logic        rst_n,
    edps_in_if.sink     pts,
    edps_out_if.source  res
);

    edps_pkg::cmd_t    cmd;
    edps_pkg::status_t status;
    logic              in_ready;

    // sequence the passes: differences, squares, ratio, update, emit
    edps_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pts.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // take a transaction only while the sequencer is idle
    assign pts.ready = in_ready;

    // hold operands, divider, multiplier and the output register
    edps_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .pts    (pts),
        .res    (res),
        .cmd    (cmd),
        .status (status)
    );

endmodule
